// ===== sv/section_address_offset_translator_assert.svh =====
// ============================================================================
// section address offset translator assertion macros
// shared property wrappers for concurrent checks, clocked and reset-qualified
// ============================================================================
`ifndef SECTION_ADDRESS_OFFSET_TRANSLATOR_ASSERT_SVH
`define SECTION_ADDRESS_OFFSET_TRANSLATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SAT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sat_pkg.sv =====
// ============================================================================
// sat_pkg
// shared widths, request codes, state and payload types of the translator
// ============================================================================
package sat_pkg;

    localparam int DATA_W           = 64;
    localparam int IDX_W            = 6;
    localparam int CNT_W            = 7;
    localparam int REQ_W            = 2;
    localparam int MAX_SECTIONS_DEF = 64;

    localparam logic [REQ_W-1:0] REQ_WRITE       = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADDR_TO_OFS = 2'd1;
    localparam logic [REQ_W-1:0] REQ_OFS_TO_ADDR = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // one table entry as stored in the memory word
    typedef struct packed {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] file_start;
    } t_entry;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  hit_index;
        logic [DATA_W-1:0] translated;
    } t_result;

    // control strobes from the sequencer
    typedef struct packed {
        logic in_ready;
        logic scan_en;
        logic out_load;
    } t_ctrl;

endpackage

// ===== sv/sat_if.sv =====
// ============================================================================
// sat interfaces
// request, response and configuration channels with valid/ready handshake
// ============================================================================
interface sat_req_if;
    logic                         valid;
    logic                         ready;
    logic [sat_pkg::REQ_W-1:0]    req_type;
    logic [sat_pkg::IDX_W-1:0]    entry_index;
    logic [sat_pkg::DATA_W-1:0]   entry_base;
    logic [sat_pkg::DATA_W-1:0]   entry_size;
    logic [sat_pkg::DATA_W-1:0]   entry_file_start;
    logic [sat_pkg::DATA_W-1:0]   query_value;

    modport source (
        output valid, req_type, entry_index, entry_base, entry_size,
               entry_file_start, query_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, entry_base, entry_size,
               entry_file_start, query_value,
        output ready
    );
endinterface

interface sat_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [sat_pkg::IDX_W-1:0]    hit_index;
    logic [sat_pkg::DATA_W-1:0]   translated;

    modport source (output valid, found, hit_index, translated, input ready);
    modport sink   (input  valid, found, hit_index, translated, output ready);
endinterface

interface sat_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [sat_pkg::CNT_W-1:0]    entry_count;

    modport source (output valid, entry_count, input ready);
    modport sink   (input  valid, entry_count, output ready);
endinterface

// ===== sv/sat_ram.sv =====
// ============================================================================
// sat_ram
// generic single-write, single-read ram with registered read data
// ============================================================================
module sat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/section_address_offset_translator.sv =====
// ============================================================================
// section_address_offset_translator
// first-match section table: address to file offset and back
// ============================================================================
// a write item is stored in the cycle it is accepted
// a query reads entries in order through the ram read, subtract and compare stages,
// stops at the first hit or after the searched count, then loads the output register
// input: writes one a cycle while idle; a query holds the input until its result
// is loaded into the output register, including any wait for that register
// reset: sequencer, valids and section count cleared, table undefined until written
// ============================================================================
`include "section_address_offset_translator_assert.svh"

module section_address_offset_translator #(
    parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sat_req_if.sink   i_req,
    sat_rsp_if.source o_rsp,
    sat_cfg_if.sink   i_cfg
);

    // address bits of the table, scan counter bits (holds the limit itself)
    localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int IW = (AW > sat_pkg::CNT_W) ? AW : sat_pkg::CNT_W;
    localparam int LW = IW + 1;
    localparam int EW = $bits(sat_pkg::t_entry);

    // ------------------------------------------------------------------------
    // sequencer and configuration
    // ------------------------------------------------------------------------
    sat_pkg::t_state r_state, n_state;
    sat_pkg::t_ctrl  ctrl;
    logic [sat_pkg::CNT_W-1:0] r_count;

    // query context latched at accept
    logic                       r_req_ofs;   // offset to address direction
    logic [sat_pkg::DATA_W-1:0] r_query;
    logic [LW-1:0]              r_limit;
    logic [LW-1:0]              r_issue;

    // read stage (ram data valid) and compare stage
    logic                       r_s1_vld;
    logic [LW-1:0]              r_s1_idx;
    logic                       r_s2_vld;
    logic [LW-1:0]              r_s2_idx;
    logic                       r_s2_ge;
    logic [sat_pkg::DATA_W-1:0] r_s2_diff;
    logic [sat_pkg::DATA_W-1:0] r_s2_size;
    logic [sat_pkg::DATA_W-1:0] r_s2_to;

    // finished result and output register
    sat_pkg::t_result r_res;
    logic             r_out_vld;
    sat_pkg::t_result r_out;

    // request decode
    logic          req_acc;
    logic          req_query;
    logic          ram_we;
    logic [LW-1:0] widx_ext;
    logic [LW-1:0] cnt_ext;
    logic [LW-1:0] lim;

    // scan datapath
    logic [EW-1:0]               ram_rdata;
    sat_pkg::t_entry             rd_entry;
    logic [sat_pkg::DATA_W-1:0]  s1_from;
    logic [sat_pkg::DATA_W-1:0]  s1_to;
    logic [sat_pkg::DATA_W:0]    s1_sub;
    logic                        s2_hit;
    logic [sat_pkg::DATA_W-1:0]  s2_trans;
    logic                        scan_issue;
    logic                        scan_miss;

    assign i_cfg.ready = 1'b1;

    // items are only taken while idle; type 3 is swallowed without a result
    assign req_acc   = i_req.valid && ctrl.in_ready;
    assign req_query = (i_req.req_type == sat_pkg::REQ_ADDR_TO_OFS) ||
                       (i_req.req_type == sat_pkg::REQ_OFS_TO_ADDR);

    // entries beyond the table are dropped
    assign widx_ext = LW'(i_req.entry_index);
    assign ram_we   = req_acc && (i_req.req_type == sat_pkg::REQ_WRITE) &&
                      (widx_ext < LW'(MAX_SECTIONS));

    // searched count clipped to the table size
    assign cnt_ext = LW'(r_count);
    assign lim     = (cnt_ext > LW'(MAX_SECTIONS)) ? LW'(MAX_SECTIONS) : cnt_ext;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sat_pkg::S_IDLE: begin
                if (req_acc && req_query) begin
                    n_state = sat_pkg::S_SCAN;
                end
            end
            sat_pkg::S_SCAN: begin
                if (s2_hit || scan_miss) begin
                    n_state = sat_pkg::S_FINISH;
                end
            end
            sat_pkg::S_FINISH: begin
                if (ctrl.out_load) begin
                    n_state = sat_pkg::S_IDLE;
                end
            end
            default: n_state = sat_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        ctrl = '0;
        unique case (r_state)
            sat_pkg::S_IDLE:   ctrl.in_ready = 1'b1;
            sat_pkg::S_SCAN:   ctrl.scan_en  = 1'b1;
            sat_pkg::S_FINISH: ctrl.out_load = !r_out_vld || o_rsp.ready;
            default:           ctrl = '0;
        endcase
    end

    assign i_req.ready = ctrl.in_ready;

    // ------------------------------------------------------------------------
    // table memory: writes only while idle, reads only while scanning,
    // so the same entry is never read and written in one cycle
    // ------------------------------------------------------------------------
    sat_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SECTIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (widx_ext[AW-1:0]),
        .i_wdata ({i_req.entry_base, i_req.entry_size, i_req.entry_file_start}),
        .i_re    (scan_issue),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // scan: issue one read a cycle, subtract, then range test and translate
    // ------------------------------------------------------------------------
    assign rd_entry = sat_pkg::t_entry'(ram_rdata);
    assign s1_from  = r_req_ofs ? rd_entry.file_start : rd_entry.base;
    assign s1_to    = r_req_ofs ? rd_entry.base       : rd_entry.file_start;
    // top bit is the borrow: set when the query lies below the range start
    assign s1_sub   = {1'b0, r_query} - {1'b0, s1_from};

    // offset from the start below size means inside, with no wrap of the end
    assign s2_hit   = r_s2_vld && r_s2_ge && (r_s2_diff < r_s2_size);
    assign s2_trans = r_s2_diff + r_s2_to;

    // stop issuing once a hit shows, later entries in flight are dropped
    assign scan_issue = ctrl.scan_en && (r_issue < r_limit) && !s2_hit;
    assign scan_miss  = ctrl.scan_en && !r_s1_vld && !r_s2_vld && (r_issue >= r_limit);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sat_pkg::S_IDLE;
            r_count   <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= scan_issue;
            r_s2_vld <= ctrl.scan_en && r_s1_vld && !s2_hit;
            if (i_cfg.valid) begin
                r_count <= i_cfg.entry_count;
            end
            if (ctrl.out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_acc && req_query) begin
            r_req_ofs <= (i_req.req_type == sat_pkg::REQ_OFS_TO_ADDR);
            r_query   <= i_req.query_value;
            r_limit   <= lim;
            r_issue   <= '0;
        end else if (scan_issue) begin
            r_issue <= r_issue + 1'b1;
        end
        if (scan_issue) begin
            r_s1_idx <= r_issue;
        end
        if (r_s1_vld) begin
            r_s2_idx  <= r_s1_idx;
            r_s2_ge   <= !s1_sub[sat_pkg::DATA_W];
            r_s2_diff <= s1_sub[sat_pkg::DATA_W-1:0];
            r_s2_size <= rd_entry.size;
            r_s2_to   <= s1_to;
        end
        if (s2_hit) begin
            r_res.found      <= 1'b1;
            r_res.hit_index  <= r_s2_idx[sat_pkg::IDX_W-1:0];
            r_res.translated <= s2_trans;
        end else if (scan_miss) begin
            r_res <= '0;
        end
        if (ctrl.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.found      = r_out.found;
    assign o_rsp.hit_index  = r_out.hit_index;
    assign o_rsp.translated = r_out.translated;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `SAT_ASSERT_IMPL(a_issue_bound, i_clk, i_rst_n,
        r_state == sat_pkg::S_SCAN, r_issue <= r_limit,
        "scan counter ran past the searched count")
    `SAT_ASSERT_IMPL(a_cmp_in_range, i_clk, i_rst_n,
        r_s2_vld, r_s2_idx < r_limit,
        "compared an entry outside the searched range")
    `SAT_ASSERT_NEXT(a_query_starts, i_clk, i_rst_n,
        req_acc && req_query, r_state == sat_pkg::S_SCAN,
        "accepted query did not start a scan")
    `SAT_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n,
        r_out_vld && !r_out.found, (r_out.hit_index == '0) && (r_out.translated == '0),
        "miss result carries nonzero index or value")

endmodule

// ===== test/section_address_offset_translator_tb.sv =====
// ============================================================================
// section_address_offset_translator_tb
// self-checking bench for the first-match section table: fills every entry,
// runs directed edge queries, then random phases of mixed writes and queries
// under several section counts, with random stalls on both channels
// ============================================================================
module section_address_offset_translator_tb;

    localparam int N_SECTIONS          = sat_pkg::MAX_SECTIONS_DEF;
    localparam int RESET_CYCLES        = 4;
    // long enough for a query that scans every entry, plus margin
    localparam int DRAIN_CYCLES        = N_SECTIONS + 8;
    localparam int RANDOM_PHASES       = 8;
    localparam int PHASE_ITEMS         = 100;
    localparam int LONG_HOLD_CYCLES    = 400;
    // room for ~900 items, each at its worst, taken several times over
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    localparam logic [sat_pkg::REQ_W-1:0]  REQ_UNUSED = 2'd3;
    localparam logic [sat_pkg::DATA_W-1:0] ALL_ONES   = '1;

    // one item on the request channel
    typedef struct packed {
        logic [sat_pkg::REQ_W-1:0]  req_type;
        logic [sat_pkg::IDX_W-1:0]  entry_index;
        logic [sat_pkg::DATA_W-1:0] entry_base;
        logic [sat_pkg::DATA_W-1:0] entry_size;
        logic [sat_pkg::DATA_W-1:0] entry_file_start;
        logic [sat_pkg::DATA_W-1:0] query_value;
    } t_request;

    // ------------------------------------------------------------------------
    // shadow section table, first-match search and queue of expected results
    // ------------------------------------------------------------------------
    class translation_scoreboard;
        logic [sat_pkg::DATA_W-1:0] base_tbl [N_SECTIONS];
        logic [sat_pkg::DATA_W-1:0] size_tbl [N_SECTIONS];
        logic [sat_pkg::DATA_W-1:0] file_tbl [N_SECTIONS];
        logic [sat_pkg::CNT_W-1:0]  entry_count;
        sat_pkg::t_result           expected_q [$];
        int unsigned                fail_count;

        function new();
            entry_count = '0;
            fail_count  = 0;
            foreach (base_tbl[i]) begin
                base_tbl[i] = '0;
                size_tbl[i] = '0;
                file_tbl[i] = '0;
            end
        endfunction

        function void set_count(logic [sat_pkg::CNT_W-1:0] value);
            entry_count = value;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // called for every accepted request item
        function void note_request(t_request r);
            sat_pkg::t_result           res;
            int unsigned                span;
            int unsigned                i;
            logic [sat_pkg::DATA_W-1:0] src_start;
            logic [sat_pkg::DATA_W-1:0] dst_start;
            case (r.req_type)
                sat_pkg::REQ_WRITE: begin
                    base_tbl[r.entry_index] = r.entry_base;
                    size_tbl[r.entry_index] = r.entry_size;
                    file_tbl[r.entry_index] = r.entry_file_start;
                end
                sat_pkg::REQ_ADDR_TO_OFS, sat_pkg::REQ_OFS_TO_ADDR: begin
                    res  = '0;
                    // counts above the table size search the whole table
                    span = (entry_count > N_SECTIONS) ? N_SECTIONS : entry_count;
                    for (i = 0; i < span; i++) begin
                        src_start = (r.req_type == sat_pkg::REQ_ADDR_TO_OFS) ?
                                    base_tbl[i] : file_tbl[i];
                        dst_start = (r.req_type == sat_pkg::REQ_ADDR_TO_OFS) ?
                                    file_tbl[i] : base_tbl[i];
                        // range end never wraps, size zero never matches
                        if (r.query_value >= src_start &&
                            (r.query_value - src_start) < size_tbl[i]) begin
                            res.found      = 1'b1;
                            res.hit_index  = sat_pkg::IDX_W'(i);
                            res.translated = r.query_value - src_start + dst_start;
                            break;
                        end
                    end
                    expected_q.push_back(res);
                end
                default: begin
                    // unused request type: no result
                end
            endcase
        endfunction

        // called for every accepted result item
        function void check_result(sat_pkg::t_result got);
            sat_pkg::t_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: found %0d hit_index %0d translated %h",
                       got.found, got.hit_index, got.translated);
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            if (got.found !== want.found) begin
                $error("found mismatch: expected %0d, actual %0d", want.found, got.found);
                fail_count++;
            end
            if (got.hit_index !== want.hit_index) begin
                $error("hit_index mismatch: expected %0d, actual %0d",
                       want.hit_index, got.hit_index);
                fail_count++;
            end
            if (got.translated !== want.translated) begin
                $error("translated mismatch: expected %h, actual %h",
                       want.translated, got.translated);
                fail_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sat_req_if req_ch ();
    sat_rsp_if rsp_ch ();
    sat_cfg_if cfg_ch ();

    translation_scoreboard sb;

    t_request         seen_req;
    sat_pkg::t_result seen_rsp;
    bit               sender_burst;
    bit               hold_off_request;
    bit               hold_off_done;
    int unsigned      cycle_count;

    section_address_offset_translator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // 10 time unit clock
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // helpers for random values and gaps
    // ------------------------------------------------------------------------
    function automatic logic [sat_pkg::DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    // every field random; callers override what matters
    function automatic t_request noise_request();
        t_request r;
        r.req_type         = sat_pkg::REQ_W'($urandom_range(0, 3));
        r.entry_index      = sat_pkg::IDX_W'($urandom_range(0, N_SECTIONS - 1));
        r.entry_base       = rand64();
        r.entry_size       = rand64();
        r.entry_file_start = rand64();
        r.query_value      = rand64();
        return r;
    endfunction

    // random entry: bases and file starts clustered so ranges overlap,
    // sizes mostly small, some empty, some huge, some reaching the top
    function automatic t_request random_entry(int unsigned idx);
        t_request    r;
        int unsigned roll;
        r             = noise_request();
        r.req_type    = sat_pkg::REQ_WRITE;
        r.entry_index = sat_pkg::IDX_W'(idx);
        case ($urandom_range(0, 3))
            0:       r.entry_base = rand64();
            1:       r.entry_base = sat_pkg::DATA_W'($urandom_range(0, 'hFFFF));
            2:       r.entry_base = ALL_ONES - $urandom_range(0, 'hFFFF);
            default: r.entry_base = 64'h4000_0000 + $urandom_range(0, 'hFFFF);
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 50)      r.entry_size = sat_pkg::DATA_W'($urandom_range(1, 'h1000));
        else if (roll < 70) r.entry_size = sat_pkg::DATA_W'($urandom_range(1, 'hFF_FFFF));
        else if (roll < 78) r.entry_size = '0;
        else if (roll < 85) r.entry_size = rand64();
        else if (roll < 95) r.entry_size = '0 - r.entry_base;
        else                r.entry_size = ALL_ONES;
        case ($urandom_range(0, 9))
            0, 1, 2:  r.entry_file_start = rand64();
            3:        r.entry_file_start = ALL_ONES - $urandom_range(0, 'hFFFF);
            4:        r.entry_file_start = sat_pkg::DATA_W'($urandom_range(0, 'hFFFF));
            default:  r.entry_file_start = 64'h10_0000 + $urandom_range(0, 'hFFFF);
        endcase
        return r;
    endfunction

    // query aimed at an entry: inside, at both edges, just outside, or anywhere
    function automatic t_request random_query();
        t_request                   r;
        int unsigned                span;
        int unsigned                pick;
        logic [sat_pkg::DATA_W-1:0] start;
        logic [sat_pkg::DATA_W-1:0] len;
        r          = noise_request();
        r.req_type = $urandom_range(0, 1) ? sat_pkg::REQ_ADDR_TO_OFS : sat_pkg::REQ_OFS_TO_ADDR;
        span       = (sb.entry_count > N_SECTIONS) ? N_SECTIONS : sb.entry_count;
        // now and then aim past the searched count
        if (span == 0 || $urandom_range(0, 7) == 0)
            pick = $urandom_range(0, N_SECTIONS - 1);
        else
            pick = $urandom_range(0, span - 1);
        start = (r.req_type == sat_pkg::REQ_ADDR_TO_OFS) ?
                sb.base_tbl[pick] : sb.file_tbl[pick];
        len   = sb.size_tbl[pick];
        case ($urandom_range(0, 11))
            0:       r.query_value = start;
            1:       r.query_value = start + len - 1;
            2:       r.query_value = start + len;
            3:       r.query_value = start - 1;
            4:       r.query_value = rand64();
            default: r.query_value = (len == 0) ? start : start + rand64() % len;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // offer one item and hold it until accepted; valid is only dropped
    // when a gap follows, so back-to-back items keep it high
    task automatic send_request(input t_request r);
        int unsigned gap;
        gap = sender_burst ? 0 : idle_length();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.req_type         <= r.req_type;
        req_ch.entry_index      <= r.entry_index;
        req_ch.entry_base       <= r.entry_base;
        req_ch.entry_size       <= r.entry_size;
        req_ch.entry_file_start <= r.entry_file_start;
        req_ch.query_value      <= r.query_value;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic send_entry(input int unsigned idx,
                              input logic [sat_pkg::DATA_W-1:0] base,
                              input logic [sat_pkg::DATA_W-1:0] size,
                              input logic [sat_pkg::DATA_W-1:0] file_start);
        t_request r;
        r                  = noise_request();
        r.req_type         = sat_pkg::REQ_WRITE;
        r.entry_index      = sat_pkg::IDX_W'(idx);
        r.entry_base       = base;
        r.entry_size       = size;
        r.entry_file_start = file_start;
        send_request(r);
    endtask

    task automatic send_query(input logic [sat_pkg::REQ_W-1:0] kind,
                              input logic [sat_pkg::DATA_W-1:0] value);
        t_request r;
        r             = noise_request();
        r.req_type    = kind;
        r.query_value = value;
        send_request(r);
    endtask

    // stop offering, let every expected result arrive, then let the block settle
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_entry_count(input logic [sat_pkg::CNT_W-1:0] value);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.entry_count <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // monitor: every handshake seen at the clock edge goes to the scoreboard
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_count(cfg_ch.entry_count);
            if (req_ch.valid && req_ch.ready) begin
                seen_req.req_type         = req_ch.req_type;
                seen_req.entry_index      = req_ch.entry_index;
                seen_req.entry_base       = req_ch.entry_base;
                seen_req.entry_size       = req_ch.entry_size;
                seen_req.entry_file_start = req_ch.entry_file_start;
                seen_req.query_value      = req_ch.query_value;
                sb.note_request(seen_req);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                seen_rsp.found      = rsp_ch.found;
                seen_rsp.hit_index  = rsp_ch.hit_index;
                seen_rsp.translated = rsp_ch.translated;
                sb.check_result(seen_rsp);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result sink: ready stretches and gaps, plus one long hold-off
    // ------------------------------------------------------------------------
    initial begin : response_sink
        int unsigned n;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_request && !hold_off_done) begin
                // block fills up and must stall its request channel
                hold_off_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            // occasionally a long stretch with no stalls at all
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
            rsp_ch.ready <= 1'b1;
            repeat (n) @(posedge clk);
            n = idle_length();
            if (n > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    // watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned k;
        int unsigned phase;
        int unsigned sent;
        int unsigned roll;
        t_request    r;

        sb               = new();
        sender_burst     = 1'b0;
        hold_off_request = 1'b0;
        hold_off_done    = 1'b0;

        // every input known from time zero
        rst_n                   <= 1'b0;
        req_ch.valid            <= 1'b0;
        req_ch.req_type         <= sat_pkg::REQ_WRITE;
        req_ch.entry_index      <= '0;
        req_ch.entry_base       <= '0;
        req_ch.entry_size       <= '0;
        req_ch.entry_file_start <= '0;
        req_ch.query_value      <= '0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.entry_count      <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // count is zero after reset: queries search nothing and miss
        send_query(sat_pkg::REQ_ADDR_TO_OFS, '0);
        send_query(sat_pkg::REQ_OFS_TO_ADDR, ALL_ONES);
        // unused request type with every field at its maximum: ignored
        send_request('1);

        // fill the whole table before any query searches it
        for (k = 0; k < N_SECTIONS; k++) begin
            case (k)
                // empty range
                0:  send_entry(k, 64'h4000_0000, '0, 64'h10_0000);
                // lowest address
                1:  send_entry(k, '0, 64'h100, 64'h20_0000);
                // range that ends exactly at the top of the address space
                2:  send_entry(k, '0 - 64'h1000, 64'h1000, 64'h30_0000);
                // two overlapping entries in both domains: first one wins
                3:  send_entry(k, 64'h5000_1000, 64'h1000, 64'h40_0000);
                4:  send_entry(k, 64'h5000_1800, 64'h1000, 64'h40_0800);
                // file range runs past the top, translation wraps
                5:  send_entry(k, 64'h6000_0000, 64'h1000, 64'hFFFF_FFFF_FFFF_F800);
                // maximum base, maximum file start
                6:  send_entry(k, ALL_ONES, 64'h1, 64'h50_0000);
                7:  send_entry(k, 64'h7000_0000, 64'h1, ALL_ONES);
                // maximum size catches nearly everything at the end of the table
                63: send_entry(k, 64'h1, ALL_ONES, '0);
                default: send_request(random_entry(k));
            endcase
        end

        wait_idle();
        write_entry_count(sat_pkg::CNT_W'(N_SECTIONS));

        // directed queries over the whole table
        send_query(sat_pkg::REQ_ADDR_TO_OFS, 64'h4000_0000);        // empty entry skipped
        send_query(sat_pkg::REQ_ADDR_TO_OFS, '0);                   // lowest address
        send_query(sat_pkg::REQ_ADDR_TO_OFS, ALL_ONES);             // last byte below the top
        send_query(sat_pkg::REQ_ADDR_TO_OFS, ('0 - 64'h1000) - 1);  // just below that range
        send_query(sat_pkg::REQ_ADDR_TO_OFS, 64'h5000_1800);        // overlap, first match
        send_query(sat_pkg::REQ_ADDR_TO_OFS, 64'h5000_2000);        // only the later entry
        send_query(sat_pkg::REQ_OFS_TO_ADDR, 64'h40_0800);          // overlap in file domain
        send_query(sat_pkg::REQ_ADDR_TO_OFS, 64'h6000_0900);        // translated value wraps
        send_query(sat_pkg::REQ_OFS_TO_ADDR, ALL_ONES);             // highest file offset
        send_query(sat_pkg::REQ_OFS_TO_ADDR, '0);                   // no match through wrap
        send_query(sat_pkg::REQ_ADDR_TO_OFS, 64'h7000_0000);        // translates to all ones
        send_query(sat_pkg::REQ_OFS_TO_ADDR, 64'h20_00FF);          // last byte of a file range

        // random phases, each under its own section count
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0:       write_entry_count('1);                     // above table size
                1:       write_entry_count(sat_pkg::CNT_W'(1));
                2:       write_entry_count(sat_pkg::CNT_W'(N_SECTIONS + 1));
                3:       write_entry_count(sat_pkg::CNT_W'(N_SECTIONS));
                4:       write_entry_count('0);
                5:       write_entry_count(sat_pkg::CNT_W'($urandom_range(2, N_SECTIONS - 1)));
                6:       write_entry_count(sat_pkg::CNT_W'($urandom_range(0, 127)));
                default: write_entry_count(sat_pkg::CNT_W'(N_SECTIONS));
            endcase
            // the long hold-off lands early in the random part
            if (phase == 0)
                hold_off_request = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 39) == 0)
                    sender_burst = !sender_burst;
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    // ignored item, not counted
                    r          = noise_request();
                    r.req_type = REQ_UNUSED;
                    send_request(r);
                end else if (roll < 28) begin
                    send_request(random_entry($urandom_range(0, N_SECTIONS - 1)));
                    sent++;
                end else begin
                    send_request(random_query());
                    sent++;
                end
            end
        end

        // all items accepted: wait for the last results and a quiet tail
        wait_idle();
        if (sb.fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
